@@ rtl/core/dad_pkg.sv @@
package dad_pkg;

	localparam int unsigned YEAR_W   = 16;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned COUNT_W  = 16;
	localparam int unsigned RED_W    = 3;

	localparam logic [YEAR_W-1:0]  YEAR_MAX   = 16'hFFFF;
	localparam logic [16:0]        RED_BASE   = 17'd400;
	localparam logic [RED_W-1:0]   RED_TOP    = 3'd7;
	localparam logic [8:0]         CYCLE_LAST = 9'd399;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LAST   = 5'd31;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} dad_status_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] days_to_add;
	} dad_in_t;

	typedef struct packed {
		logic [DAY_W-1:0]   new_day;
		logic [MONTH_W-1:0] new_month;
		logic [YEAR_W-1:0]  new_year;
		logic [1:0]         status;
	} dad_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_CHECK,
		S_STEP,
		S_FINISH
	} dad_state_t;

	typedef struct packed {
		logic             load;
		logic             reduce;
		logic [RED_W-1:0] red_idx;
		logic             mark_bad;
		logic             step;
		logic             capture;
	} dad_cmd_t;

	typedef struct packed {
		logic bad_date;
		logic step_last;
	} dad_sts_t;

	// The argument is the year modulo 400; every fourth year is a leap year
	// unless it is a century that is not a multiple of 400.
	function automatic logic dad_leap(input logic [8:0] r);
		logic quad;
		logic century;
		quad    = (r[1:0] == 2'd0);
		century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
		return (r == 9'd0) || (quad && !century);
	endfunction

	function automatic logic [DAY_W-1:0] dad_month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

@@ rtl/core/date_add_days.sv @@
// Gregorian date adder.
// The item channel (item_valid, item_stall, item) takes a start date and a
// count of days; the result channel (result_valid, result_stall, result)
// returns the new date with a status word: ok, invalid start date, or year
// overflow with the date saturated at the last day of year 65535.
// One word is worked on at a time. After a word is accepted, the year is
// reduced modulo 400 by subtracting shifted multiples of 400, the date is
// checked, then the adder walks one month per cycle, and the output register
// is loaded once it is free; an invalid date skips the walk. The walk crosses
// at most about 2160 month boundaries (for 65535 days) and sets the rate.
// The next word can be accepted in the cycle after the output register loads.
// item_stall is low only while the block is idle. A finished result sits in
// the output register while result_stall is high; the next word can be
// accepted and worked on meanwhile, and it waits for that register to free.
// Reset clears the controller and the output valid flag; no clearing pass.
module date_add_days
	import dad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	input  dad_in_t  item,
	output logic     result_valid,
	input  logic     result_stall,
	output dad_out_t result
);

	dad_cmd_t cmd;
	dad_sts_t sts;

	dad_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	dad_dp u_dp (
		.clk    (clk),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	// An accepted word keeps the input side busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not held off after accepting a word");

	a_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_OVERFLOW) |->
		(result.new_day == DAY_LAST) && (result.new_month == MONTH_DEC) &&
		(result.new_year == YEAR_MAX))
		else $error("overflow result is not the saturated date");

	a_ok_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_OK) |->
		(result.new_month >= MONTH_JAN) && (result.new_month <= MONTH_DEC) &&
		(result.new_day >= DAY_FIRST))
		else $error("ok result carries an impossible date");

endmodule

@@ rtl/core/dad_ctrl.sv @@
module dad_ctrl
	import dad_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	output logic     result_valid,
	input  logic     result_stall,
	input  dad_sts_t sts,
	output dad_cmd_t cmd
);

	dad_state_t       state_q, state_nx;
	logic [RED_W-1:0] red_q, red_nx;
	logic             out_vld_q;
	logic             out_free;

	assign out_free     = !out_vld_q || !result_stall;
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			red_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			red_q   <= red_nx;
			if (cmd.capture) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx     = state_q;
		red_nx       = red_q;
		cmd          = '0;
		cmd.red_idx  = red_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					red_nx   = RED_TOP;
					state_nx = S_REDUCE;
				end
			end
			S_REDUCE: begin
				cmd.reduce = 1'b1;
				red_nx     = red_q - 1'b1;
				if (red_q == '0) begin
					state_nx = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.bad_date) begin
					cmd.mark_bad = 1'b1;
					state_nx     = S_FINISH;
				end else begin
					state_nx = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				if (sts.step_last) begin
					state_nx = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/dad_dp.sv @@
module dad_dp
	import dad_pkg::*;
(
	input  logic     clk,
	input  dad_in_t  item,
	input  dad_cmd_t cmd,
	output dad_sts_t sts,
	output dad_out_t result
);

	logic [DAY_W-1:0]   d_q;
	logic [MONTH_W-1:0] m_q;
	logic [YEAR_W-1:0]  y_q;
	logic [COUNT_W-1:0] n_q;
	logic [YEAR_W-1:0]  rem_q;
	dad_status_t        st_q;
	dad_out_t           res_q;

	logic [DAY_W-1:0]   len;
	logic [16:0]        red_const;
	logic [16:0]        sum;
	logic               fits;
	logic               at_end;

	// Once the reduction has run, rem_q holds the year modulo 400.
	assign len       = dad_month_len(m_q, dad_leap(rem_q[8:0]));
	assign red_const = RED_BASE << cmd.red_idx;
	assign sum       = {12'd0, d_q} + {1'b0, n_q};
	assign fits      = (sum <= {12'd0, len});
	assign at_end    = (m_q == MONTH_DEC) && (y_q == YEAR_MAX);

	assign sts.bad_date  = (m_q == '0) || (m_q > MONTH_DEC) || (d_q == '0) || (d_q > len);
	assign sts.step_last = (n_q == '0) || fits || at_end;
	assign result        = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			d_q   <= item.day;
			m_q   <= item.month;
			y_q   <= item.year;
			n_q   <= item.days_to_add;
			rem_q <= item.year;
			st_q  <= ST_OK;
		end
		if (cmd.reduce && ({1'b0, rem_q} >= red_const)) begin
			rem_q <= rem_q - red_const[YEAR_W-1:0];
		end
		if (cmd.mark_bad) begin
			st_q <= ST_INVALID;
		end
		if (cmd.step && (n_q != '0)) begin
			if (fits) begin
				d_q <= sum[DAY_W-1:0];
				n_q <= '0;
			end else if (at_end) begin
				d_q  <= DAY_LAST;
				n_q  <= '0;
				st_q <= ST_OVERFLOW;
			end else begin
				// The remainder restarts at day one of the next month.
				n_q <= COUNT_W'(sum - {12'd0, len} - 17'd1);
				d_q <= DAY_FIRST;
				if (m_q == MONTH_DEC) begin
					m_q   <= MONTH_JAN;
					y_q   <= y_q + 1'b1;
					rem_q <= (rem_q == {7'd0, CYCLE_LAST}) ? '0 : rem_q + 1'b1;
				end else begin
					m_q <= m_q + 1'b1;
				end
			end
		end
		if (cmd.capture) begin
			res_q.new_day   <= d_q;
			res_q.new_month <= m_q;
			res_q.new_year  <= y_q;
			res_q.status    <= st_q;
		end
	end

endmodule
